// ===== sv/pixel_rle_hex_encoder_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pixel run-length hex encoder
// Concurrent checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PIXEL_RLE_HEX_ENCODER_MACROS_SVH
`define PIXEL_RLE_HEX_ENCODER_MACROS_SVH

`ifndef SYNTHESIS

// The condition must hold at every clock edge.
`define PRHE_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("pixel_rle_hex_encoder: invariant violated");

// The consequent must hold in the same cycle as the antecedent.
`define PRHE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pixel_rle_hex_encoder: implication violated");

// The consequent must hold in the cycle after the antecedent.
`define PRHE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pixel_rle_hex_encoder: next-cycle check violated");

`else

`define PRHE_ASSERT_ALWAYS(label, expr)
`define PRHE_ASSERT_IMP(label, ante, cons)
`define PRHE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== sv/prhe_pkg.sv =====
// ----------------------------------------------------------------------------
// Pixel run-length hex encoder package
// Widths, the run cap and the hex digit encoding shared by the encoder.
// ----------------------------------------------------------------------------
package prhe_pkg;

  localparam int PixelW   = 8;
  localparam int LenW     = 16;
  localparam int DigitW   = 7;
  localparam int RecW     = 6 * DigitW;
  localparam int TdataOutW = ((RecW + 7) / 8) * 8;
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  localparam logic [LenW-1:0] RunCap = 16'hFFFF;

  typedef logic [RecW-1:0] record_t;

  // Lower-case ASCII hex digit for one nibble.
  function automatic logic [DigitW-1:0] hex_digit(input logic [3:0] nib);
    logic [DigitW-1:0] d;
    case (nib)
      4'h0: d = 7'h30;
      4'h1: d = 7'h31;
      4'h2: d = 7'h32;
      4'h3: d = 7'h33;
      4'h4: d = 7'h34;
      4'h5: d = 7'h35;
      4'h6: d = 7'h36;
      4'h7: d = 7'h37;
      4'h8: d = 7'h38;
      4'h9: d = 7'h39;
      4'ha: d = 7'h61;
      4'hb: d = 7'h62;
      4'hc: d = 7'h63;
      4'hd: d = 7'h64;
      4'he: d = 7'h65;
      default: d = 7'h66;
    endcase
    return d;
  endfunction

  // Record packed with the most significant count digit in the lowest bits.
  function automatic record_t make_record(input logic [LenW-1:0] len,
                                          input logic [PixelW-1:0] val);
    return {hex_digit(val[3:0]), hex_digit(val[7:4]),
            hex_digit(len[3:0]), hex_digit(len[7:4]),
            hex_digit(len[11:8]), hex_digit(len[15:12])};
  endfunction

endpackage

// ===== sv/pixel_rle_hex_encoder.sv =====
// ----------------------------------------------------------------------------
// Pixel run-length hex encoder
// Turns a raster stream of pixel bytes into six-digit ASCII hex run records.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one pixel byte per transaction in in_tdata, with
//   in_tlast on the last pixel of a frame. Equal pixels form a run of up to
//   65535 pixels. A run is closed by a different pixel, by a repeat at the
//   cap, or by the end of the frame; each closed run leaves as one output
//   transaction of four count digits and two value digits, with out_tlast set
//   on the last record of the frame.
//   The run state is updated on the edge that accepts a pixel, and any record
//   it causes is written into the record queue on that same edge. One
//   pixel per cycle is taken while the receiver keeps up; a pixel that both
//   closes a run and ends the frame yields two records.
//   Records wait in a four-entry queue. in_tready stays high while at least
//   two entries are free, so a stalled receiver lets pixels in until three
//   or more records wait, and then the input side is held off.
//   After reset no run is open and the queue is empty.
// ----------------------------------------------------------------------------
`include "pixel_rle_hex_encoder_macros.svh"

module pixel_rle_hex_encoder (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: pixel[7:0]
  input  logic [prhe_pkg::PixelW-1:0]    in_tdata,
  input  logic                           in_tlast,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // out_tdata: count_digit_3[6:0], count_digit_2[13:7], count_digit_1[20:14],
  //            count_digit_0[27:21], value_digit_1[34:28],
  //            value_digit_0[41:35], zero fill[47:42]
  output logic [prhe_pkg::TdataOutW-1:0] out_tdata,
  output logic                           out_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready
);

  // Run state
  logic [prhe_pkg::PixelW-1:0] run_pixel_r, run_pixel_nxt;
  logic [prhe_pkg::LenW-1:0]   run_length_r, run_length_nxt;
  logic                        run_open_r, run_open_nxt;

  // Record queue
  prhe_pkg::record_t           q_data_r [prhe_pkg::QDepth];
  logic                        q_last_r [prhe_pkg::QDepth];
  logic [prhe_pkg::QPtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [prhe_pkg::QPtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [prhe_pkg::QCntW-1:0]  q_count_r, q_count_nxt;

  logic                        in_fire;
  logic                        out_fire;
  logic                        extend;
  logic                        close_valid;
  logic                        final_valid;
  logic [prhe_pkg::PixelW-1:0] cur_pixel;
  logic [prhe_pkg::LenW-1:0]   cur_length;
  prhe_pkg::record_t           close_rec;
  prhe_pkg::record_t           final_rec;
  logic [1:0]                  push_n;

  assign in_tready = (q_count_r <= prhe_pkg::QCntW'(prhe_pkg::QDepth - 2));
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = (q_count_r != '0);
  assign out_fire  = out_tvalid && out_tready;

  always_comb begin
    extend      = run_open_r && (in_tdata == run_pixel_r) &&
                  (run_length_r != prhe_pkg::RunCap);
    close_valid = run_open_r && !extend;
    final_valid = in_tlast;
    cur_pixel   = extend ? run_pixel_r : in_tdata;
    cur_length  = extend ? (run_length_r + 16'd1) : 16'd1;
    close_rec   = prhe_pkg::make_record(run_length_r, run_pixel_r);
    final_rec   = prhe_pkg::make_record(cur_length, cur_pixel);
    push_n      = {1'b0, close_valid} + {1'b0, final_valid};

    run_pixel_nxt  = run_pixel_r;
    run_length_nxt = run_length_r;
    run_open_nxt   = run_open_r;
    if (in_fire) begin
      run_pixel_nxt  = cur_pixel;
      run_length_nxt = in_tlast ? '0 : cur_length;
      run_open_nxt   = !in_tlast;
    end

    wr_ptr_nxt  = wr_ptr_r + (in_fire ? prhe_pkg::QPtrW'(push_n) : '0);
    rd_ptr_nxt  = rd_ptr_r + (out_fire ? prhe_pkg::QPtrW'(1) : '0);
    q_count_nxt = q_count_r + (in_fire ? prhe_pkg::QCntW'(push_n) : '0)
                  - (out_fire ? prhe_pkg::QCntW'(1) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_pixel_r  <= '0;
      run_length_r <= '0;
      run_open_r   <= 1'b0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      q_count_r    <= '0;
    end else begin
      run_pixel_r  <= run_pixel_nxt;
      run_length_r <= run_length_nxt;
      run_open_r   <= run_open_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      q_count_r    <= q_count_nxt;
    end
  end

  // The closed run, when there is one, goes ahead of the final record.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (close_valid) begin
        q_data_r[wr_ptr_r] <= close_rec;
        q_last_r[wr_ptr_r] <= 1'b0;
      end else if (final_valid) begin
        q_data_r[wr_ptr_r] <= final_rec;
        q_last_r[wr_ptr_r] <= 1'b1;
      end
      if (close_valid && final_valid) begin
        q_data_r[wr_ptr_r + prhe_pkg::QPtrW'(1)] <= final_rec;
        q_last_r[wr_ptr_r + prhe_pkg::QPtrW'(1)] <= 1'b1;
      end
    end
  end

  assign out_tdata = {{(prhe_pkg::TdataOutW - prhe_pkg::RecW){1'b0}}, q_data_r[rd_ptr_r]};
  assign out_tlast = q_last_r[rd_ptr_r];

  `PRHE_ASSERT_ALWAYS(a_q_bound, q_count_r <= prhe_pkg::QCntW'(prhe_pkg::QDepth))
  `PRHE_ASSERT_NEXT(a_frame_closes_run, in_fire && in_tlast,
                    !run_open_r && (run_length_r == '0))
  `PRHE_ASSERT_NEXT(a_run_open_nonzero, in_fire && !in_tlast,
                    run_open_r && (run_length_r != '0))
  `PRHE_ASSERT_IMP(a_ptr_gap, 1'b1,
                   prhe_pkg::QPtrW'(wr_ptr_r - rd_ptr_r) == prhe_pkg::QPtrW'(q_count_r))

endmodule
